/* sv/rct_pkg.sv */
package rct_pkg;

  localparam int Levels       = 3;
  localparam int BitsPerLevel = 4;
  localparam int PoolTables   = 64;

  localparam int SlotsPerTable = 1 << BitsPerLevel;
  localparam int SlotCount     = PoolTables * SlotsPerTable;
  localparam int TableW        = $clog2(PoolTables);
  localparam int CountW        = $clog2(PoolTables + 1);
  localparam int AddrW         = TableW + BitsPerLevel;
  localparam int LevelW        = (Levels > 1) ? $clog2(Levels) : 1;

  localparam int CmdW  = 2;
  localparam int SelW  = 12;
  localparam int CapW  = 64;
  localparam int StatW = 2;
  localparam int PermW = 5;

  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CmdW-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd2;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_NOMEM    = 2'd1;
  localparam logic [StatW-1:0] ST_OCCUPIED = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [SelW-1:0] selector;
    logic [CapW-1:0] cap_value;
  } rct_req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [CapW-1:0]  cap_out;
  } rct_rsp_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [CapW-1:0]  wdata;
  } rct_mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_DONE
  } rct_state_t;

  function automatic logic [BitsPerLevel-1:0] group_of(input logic [SelW-1:0] sel,
                                                       input logic [LevelW-1:0] level);
    logic [SelW-1:0] sh;
    sh = sel >> (BitsPerLevel * int'(level));
    return sh[BitsPerLevel-1:0];
  endfunction

  // interior slot: 0 is empty, else child table number plus one
  function automatic logic is_link(input logic [CapW-1:0] v);
    return (v != '0) && (v <= CapW'(PoolTables));
  endfunction

endpackage

/* sv/radix_capability_table.sv */
// channel  signals                      payload
// request  req_valid / req_ready        req : command, selector, cap_value
// response rsp_valid / rsp_ready        rsp : status, cap_out
//
// One request at a time. A walk takes a read, then a check, per level on the
// single-port slot memory, after a root step; a done step follows. Each table
// allocated on the way is cleared slot by slot, all 16 slots. A finished
// response sits in the output register; the next request is taken meanwhile.
// Reset empties the tree and the pool.
module radix_capability_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  rct_pkg::rct_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rct_pkg::rct_rsp_t rsp
);
  import rct_pkg::*;

  rct_mem_req_t    mreq;
  logic [CapW-1:0] rdata;
  logic            res_valid;
  logic            res_take;
  rct_rsp_t        res;

  rct_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  rct_slot_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  assign res_take = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_NOMEM ||
                   rsp.status == ST_OCCUPIED))
    else $error("unknown status code");

  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.cap_out == '0)
    else $error("failed request returned a capability");

endmodule

/* sv/rct_slot_mem.sv */
module rct_slot_mem (
  input  logic                 clk,
  input  rct_pkg::rct_mem_req_t mreq,
  output logic [rct_pkg::CapW-1:0] rdata
);
  import rct_pkg::*;

  logic [CapW-1:0] mem [SlotCount];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.addr] <= mreq.wdata;
    end
    rdata <= mem[mreq.addr];
  end

endmodule

/* sv/rct_walk.sv */
module rct_walk (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  rct_pkg::rct_req_t        req,
  output logic                     res_valid,
  input  logic                     res_take,
  output rct_pkg::rct_rsp_t        res,
  output rct_pkg::rct_mem_req_t    mreq,
  input  logic [rct_pkg::CapW-1:0] rdata
);
  import rct_pkg::*;

  rct_state_t state, state_next;
  logic [CmdW-1:0] cmd, cmd_next;
  logic [SelW-1:0] sel, sel_next;
  logic [CapW-1:0] cap, cap_next;
  logic alloc, alloc_next;
  logic root_valid, root_valid_next;
  logic [TableW-1:0] root_table, root_table_next;
  logic [CountW-1:0] used, used_next;
  logic [TableW-1:0] cur, cur_next;
  logic [LevelW-1:0] level, level_next;
  logic [BitsPerLevel-1:0] clr_idx, clr_idx_next;
  logic [StatW-1:0] st, st_next;
  logic [CapW-1:0] res_cap, res_cap_next;

  logic pool_full;
  logic [TableW-1:0] new_table;

  assign pool_full = (used == CountW'(PoolTables));
  assign new_table = used[TableW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_valid <= 1'b0;
      used       <= '0;
    end else begin
      state      <= state_next;
      root_valid <= root_valid_next;
      used       <= used_next;
    end
    cmd        <= cmd_next;
    sel        <= sel_next;
    cap        <= cap_next;
    alloc      <= alloc_next;
    root_table <= root_table_next;
    cur        <= cur_next;
    level      <= level_next;
    clr_idx    <= clr_idx_next;
    st         <= st_next;
    res_cap    <= res_cap_next;
  end

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    sel_next        = sel;
    cap_next        = cap;
    alloc_next      = alloc;
    root_valid_next = root_valid;
    root_table_next = root_table;
    used_next       = used;
    cur_next        = cur;
    level_next      = level;
    clr_idx_next    = clr_idx;
    st_next         = st;
    res_cap_next    = res_cap;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    mreq.we         = 1'b0;
    mreq.addr       = {cur, group_of(sel, level)};
    mreq.wdata      = cap;

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd_next     = req.command;
          sel_next     = req.selector;
          cap_next     = req.cap_value;
          alloc_next   = ((req.command == CMD_UPDATE) && (|req.cap_value[PermW-1:0])) ||
                         (req.command == CMD_INSERT);
          st_next      = ST_OK;
          res_cap_next = '0;
          if (req.command == CMD_LOOKUP || req.command == CMD_UPDATE ||
              req.command == CMD_INSERT) begin
            state_next = S_ROOT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ROOT: begin
        level_next = LevelW'(Levels - 1);
        if (root_valid) begin
          cur_next   = root_table;
          state_next = S_READ;
        end else if (!alloc) begin
          state_next = S_DONE;
        end else if (pool_full) begin
          st_next    = ST_NOMEM;
          state_next = S_DONE;
        end else begin
          root_valid_next = 1'b1;
          root_table_next = new_table;
          cur_next        = new_table;
          used_next       = used + 1'b1;
          clr_idx_next    = '0;
          state_next      = S_CLEAR;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (level != '0) begin
          if (is_link(rdata)) begin
            cur_next   = rdata[TableW-1:0] - 1'b1;
            level_next = level - 1'b1;
            state_next = S_READ;
          end else if (!alloc) begin
            state_next = S_DONE;
          end else if (pool_full) begin
            st_next    = ST_NOMEM;
            state_next = S_DONE;
          end else begin
            mreq.we      = 1'b1;
            mreq.wdata   = CapW'(used) + CapW'(1);
            cur_next     = new_table;
            used_next    = used + 1'b1;
            level_next   = level - 1'b1;
            clr_idx_next = '0;
            state_next   = S_CLEAR;
          end
        end else begin
          case (cmd)
            CMD_LOOKUP: res_cap_next = rdata;
            CMD_UPDATE: begin
              res_cap_next = rdata;
              mreq.we      = 1'b1;
            end
            CMD_INSERT: begin
              if (rdata != '0) begin
                st_next = ST_OCCUPIED;
              end else begin
                mreq.we = 1'b1;
              end
            end
            default: ;
          endcase
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        mreq.we      = 1'b1;
        mreq.addr    = {cur, clr_idx};
        mreq.wdata   = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == '1) begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res.status  = st;
  assign res.cap_out = res_cap;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import rct_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  localparam int PATH_FOUND   = 0;
  localparam int PATH_NOMEM   = 1;
  localparam int PATH_MISSING = 2;

  localparam int DrainCycles = 100;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  rct_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  rct_rsp_t rsp;

  radix_capability_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // shadow of the tree
  bit              tree_root_valid;
  int              tree_root;
  logic [CapW-1:0] cap_slots [SlotCount];
  int              tables_taken;
  int              nomem_count;

  rct_rsp_t awaited_rsp [$];
  int       err_count;

  bit sender_gaps_on;
  bit rsp_stalls_on;
  int burst_left;

  logic [31:0] stall_bits;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL radix_capability_table");
    $finish;
  end

  function automatic bit take_table(output int t);
    int i;
    t = 0;
    if (tables_taken >= PoolTables) return 1'b0;
    t = tables_taken;
    tables_taken++;
    for (i = 0; i < SlotsPerTable; i++) cap_slots[t * SlotsPerTable + i] = '0;
    return 1'b1;
  endfunction

  function automatic int find_leaf(input logic [SelW-1:0] sel, input bit alloc,
                                   output int leaf);
    int              cur;
    int              t;
    int              lvl;
    int              a;
    logic [CapW-1:0] v;
    leaf = 0;
    if (!tree_root_valid) begin
      if (!alloc) return PATH_MISSING;
      if (!take_table(t)) return PATH_NOMEM;
      tree_root_valid = 1'b1;
      tree_root       = t;
    end
    cur = tree_root;
    for (lvl = Levels - 1; lvl > 0; lvl--) begin
      a = cur * SlotsPerTable + ((int'(sel) >> (lvl * BitsPerLevel)) & (SlotsPerTable - 1));
      v = cap_slots[a];
      if (v == '0 || v > CapW'(PoolTables)) begin
        if (!alloc) return PATH_MISSING;
        if (!take_table(t)) return PATH_NOMEM;
        cap_slots[a] = CapW'(t + 1);
        cur          = t;
      end else begin
        cur = int'(v) - 1;
      end
    end
    leaf = cur * SlotsPerTable + (int'(sel) & (SlotsPerTable - 1));
    return PATH_FOUND;
  endfunction

  function automatic rct_rsp_t predict_cap_op(input rct_req_t r);
    rct_rsp_t o;
    int       leaf;
    int       code;
    bit       perm;
    o.status  = ST_OK;
    o.cap_out = '0;
    case (r.command)
      CMD_LOOKUP: begin
        if (find_leaf(r.selector, 1'b0, leaf) == PATH_FOUND) o.cap_out = cap_slots[leaf];
      end
      CMD_UPDATE: begin
        perm = |r.cap_value[PermW-1:0];
        code = find_leaf(r.selector, perm, leaf);
        if (code == PATH_FOUND) begin
          o.cap_out       = cap_slots[leaf];
          cap_slots[leaf] = r.cap_value;
        end else if (perm) begin
          o.status = ST_NOMEM;
        end
      end
      CMD_INSERT: begin
        code = find_leaf(r.selector, 1'b1, leaf);
        if (code != PATH_FOUND) o.status = ST_NOMEM;
        else if (cap_slots[leaf] != '0) o.status = ST_OCCUPIED;
        else cap_slots[leaf] = r.cap_value;
      end
      default: ;
    endcase
    if (o.status == ST_NOMEM) nomem_count++;
    return o;
  endfunction

  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [SelW-1:0] sel,
                              input logic [CapW-1:0] cap);
    rct_req_t item;
    int       gap;
    item.command   = cmd;
    item.selector  = sel;
    item.cap_value = cap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = sender_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    burst_left--;
    awaited_rsp.push_back(predict_cap_op(item));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CapW-1:0] rand_cap();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom, $urandom} & ~CapW'(5'h1F);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [BitsPerLevel-1:0] pick_group();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return 4'd7;
      default: return '1;
    endcase
  endfunction

  // paths restricted to a few groups so the pool holds out
  function automatic logic [SelW-1:0] known_sel();
    logic [BitsPerLevel-1:0] leaf;
    leaf = ($urandom_range(0, 1) == 0) ? BitsPerLevel'($urandom_range(0, 15))
                                       : ($urandom_range(0, 1) ? '1 : '0);
    return {pick_group(), pick_group(), leaf};
  endfunction

  task automatic send_random(input bit known_only);
    logic [CmdW-1:0] cmd;
    logic [CapW-1:0] cap;
    logic [SelW-1:0] sel;
    int              pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) cmd = CMD_LOOKUP;
    else if (pick < 12) cmd = CMD_UPDATE;
    else if (pick < 19) cmd = CMD_INSERT;
    else cmd = CMD_UNUSED;
    cap = rand_cap();
    sel = known_sel();
    // lookups, unused commands and zero-permission updates never allocate
    if (!known_only || cmd == CMD_LOOKUP || cmd == CMD_UNUSED ||
        (cmd == CMD_UPDATE && cap[PermW-1:0] == '0)) begin
      if ($urandom_range(0, 1)) sel = SelW'($urandom_range(0, 4095));
    end
    send_request(cmd, sel, cap);
  endtask

  task automatic test_empty_tree();
    send_request(CMD_LOOKUP, 12'h000, 64'h0);
    send_request(CMD_LOOKUP, 12'hFFF, '1);
    send_request(CMD_UPDATE, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFE0);
    send_request(CMD_UNUSED, 12'hA5A, '1);
    send_request(CMD_LOOKUP, 12'hFFF, '0);
    wait_drained();
  endtask

  task automatic test_slot_ops();
    send_request(CMD_INSERT, 12'h000, '1);
    send_request(CMD_LOOKUP, 12'h000, '0);
    send_request(CMD_INSERT, 12'h000, 64'h1234_5678_9ABC_DEF1);
    send_request(CMD_UPDATE, 12'h000, 64'h0);
    send_request(CMD_LOOKUP, 12'h000, '1);
    send_request(CMD_INSERT, 12'h000, 64'h0);
    send_request(CMD_INSERT, 12'h000, 64'h0);
    send_request(CMD_UPDATE, 12'hFFF, 64'h8000_0000_0000_001F);
    send_request(CMD_UPDATE, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFE0);
    send_request(CMD_LOOKUP, 12'hFFF, '0);
    send_request(CMD_UPDATE, 12'hFFE, 64'h0000_0000_0000_0001);
    send_request(CMD_INSERT, 12'hFF0, 64'h5555_5555_5555_5555);
    send_request(CMD_LOOKUP, 12'h0F0, '1);
    send_request(CMD_UPDATE, 12'h0F0, 64'hAAAA_AAAA_AAAA_AAA0);
    send_request(CMD_UNUSED, 12'hFFF, 64'h0000_0000_0000_001F);
    send_request(CMD_LOOKUP, 12'hFFE, '0);
    wait_drained();
  endtask

  task automatic test_random_known_paths();
    int n;
    sender_gaps_on = 1'b0;
    rsp_stalls_on  = 1'b0;
    for (n = 0; n < 60; n++) send_random(1'b1);
    wait_drained();
    sender_gaps_on = 1'b1;
    rsp_stalls_on  = 1'b1;
    for (n = 0; n < 190; n++) send_random(1'b1);
    wait_drained();
  endtask

  // allocate on random paths until the pool runs dry and 12 requests met ST_NOMEM, partial walks included
  task automatic test_pool_exhaustion();
    int nomem_at_start;
    nomem_at_start = nomem_count;
    while (tables_taken < PoolTables || nomem_count - nomem_at_start < 12) begin
      if ($urandom_range(0, 1))
        send_request(CMD_INSERT, SelW'($urandom_range(0, 4095)), rand_cap());
      else
        send_request(CMD_UPDATE, SelW'($urandom_range(0, 4095)), rand_cap() | CapW'(1));
    end
    wait_drained();
  endtask

  task automatic test_random_after_exhaustion();
    int n;
    for (n = 0; n < 130; n++) send_random(1'b0);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_bits = ($urandom_range(0, 3) == 0 || !rsp_stalls_on) ? '1 : ($urandom | $urandom);
      stall_left = 32;
    end
    rsp_ready <= stall_bits[0];
    stall_bits = {stall_bits[0], stall_bits[31:1]};
    stall_left--;
  end

  always @(posedge clk) begin
    rct_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected response: status %0d, cap_out %h", rsp.status, rsp.cap_out);
        err_count++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          err_count++;
        end
        if (rsp.cap_out !== want.cap_out) begin
          $error("cap_out: expected %h, actual %h", want.cap_out, rsp.cap_out);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    rsp_ready       = 1'b0;
    tree_root_valid = 1'b0;
    tree_root       = 0;
    tables_taken    = 0;
    nomem_count     = 0;
    err_count       = 0;
    burst_left      = 0;
    stall_left      = 0;
    stall_bits      = '1;
    sender_gaps_on  = 1'b1;
    rsp_stalls_on   = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_tree();
    test_slot_ops();
    test_random_known_paths();
    test_pool_exhaustion();
    test_random_after_exhaustion();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0 && awaited_rsp.size() == 0) begin
      $display("PASS radix_capability_table");
    end else begin
      $display("FAIL radix_capability_table");
    end
    $finish;
  end

endmodule
